// ===== rtl/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package rmq_pkg;

	localparam int DATA_WIDTH    = 16;
	localparam int FRAC_BITS_DEF = 14;

	// Branch codes reported on branch_taken
	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_DIAG0 = 2'd1;
	localparam logic [1:0] BR_DIAG1 = 2'd2;
	localparam logic [1:0] BR_DIAG2 = 2'd3;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] m_0_0;
		logic signed [DATA_WIDTH-1:0] m_0_1;
		logic signed [DATA_WIDTH-1:0] m_0_2;
		logic signed [DATA_WIDTH-1:0] m_1_0;
		logic signed [DATA_WIDTH-1:0] m_1_1;
		logic signed [DATA_WIDTH-1:0] m_1_2;
		logic signed [DATA_WIDTH-1:0] m_2_0;
		logic signed [DATA_WIDTH-1:0] m_2_1;
		logic signed [DATA_WIDTH-1:0] m_2_2;
	} mat_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quat_w;
		logic signed [DATA_WIDTH-1:0] quat_x;
		logic signed [DATA_WIDTH-1:0] quat_y;
		logic signed [DATA_WIDTH-1:0] quat_z;
		logic [1:0]                   branch_taken;
		logic                         bad_input;
	} quat_t;

	// Control that rides along the pipeline with each item
	typedef struct packed {
		logic [1:0] br;
		logic       bad;
	} side_t;

endpackage

// ===== rtl/rmq_front.sv =====
// Front stage: branch selection, root argument and element pair sums and differences.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_front import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int AW        = 20,
	parameter int SW        = 16,
	parameter int PW        = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  mat_t                 mat,
	output logic                 out_vld,
	output logic [2*SW-1:0]      out_rad,
	output side_t                out_side,
	output logic [2:0][PW-1:0]   out_pairs
);

	logic signed [AW-1:0] e00, e11, e22, trace, one, arg;
	logic signed [PW-1:0] d12, d20, d01, s10, s20, s21;
	logic [1:0]           br;
	logic                 bad;
	logic [2*SW-1:0]      rad;
	logic [2:0][PW-1:0]   pairs;

	logic                 vld_s1;
	logic [2*SW-1:0]      rad_s1;
	side_t                side_s1;
	logic [2:0][PW-1:0]   pairs_s1;

	assign e00   = AW'(mat.m_0_0);
	assign e11   = AW'(mat.m_1_1);
	assign e22   = AW'(mat.m_2_2);
	assign one   = AW'(1) <<< FRAC_BITS;
	assign trace = e00 + e11 + e22;

	assign d12 = PW'(mat.m_1_2) - PW'(mat.m_2_1);
	assign d20 = PW'(mat.m_2_0) - PW'(mat.m_0_2);
	assign d01 = PW'(mat.m_0_1) - PW'(mat.m_1_0);
	assign s10 = PW'(mat.m_1_0) + PW'(mat.m_0_1);
	assign s20 = PW'(mat.m_2_0) + PW'(mat.m_0_2);
	assign s21 = PW'(mat.m_2_1) + PW'(mat.m_1_2);

	// Ties keep the earlier diagonal element
	always_comb begin
		if (!trace[AW-1]) begin
			br = BR_TRACE;
		end else if (e11 > e00) begin
			br = (e22 > e11) ? BR_DIAG2 : BR_DIAG1;
		end else begin
			br = (e22 > e00) ? BR_DIAG2 : BR_DIAG0;
		end
	end

	// Pairs go in ascending order of the slots that the half root leaves free
	always_comb begin
		unique case (br)
			BR_TRACE: begin
				arg   = trace + one;
				pairs = {d01, d20, d12};
			end
			BR_DIAG0: begin
				arg   = e00 - (e11 + e22) + one;
				pairs = {s20, s10, d12};
			end
			BR_DIAG1: begin
				arg   = e11 - (e22 + e00) + one;
				pairs = {s21, s10, d20};
			end
			default: begin
				arg   = e22 - (e00 + e11) + one;
				pairs = {s21, s20, d01};
			end
		endcase
	end

	assign bad = arg[AW-1] || (arg == '0);
	assign rad = bad ? '0 : ({{(2*SW-AW+1){1'b0}}, arg[AW-2:0]} << FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1   <= rad;
			side_s1  <= '{br: br, bad: bad};
			pairs_s1 <= pairs;
		end
	end

	assign out_vld   = vld_s1;
	assign out_rad   = rad_s1;
	assign out_side  = side_s1;
	assign out_pairs = pairs_s1;

endmodule

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with side data.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_sqrt import rmq_pkg::*; #(
	parameter int SW = 16,
	parameter int PW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [2*SW-1:0]      in_rad,
	input  side_t                in_side,
	input  logic [2:0][PW-1:0]   in_pairs,
	output logic                 out_vld,
	output logic [SW-1:0]        out_root,
	output side_t                out_side,
	output logic [2:0][PW-1:0]   out_pairs
);

	localparam int RMW = SW + 3;

	logic                 vld_s   [1:SW];
	logic [RMW-1:0]       rem_s   [1:SW];
	logic [SW-1:0]        root_s  [1:SW];
	logic [2*SW-1:0]      rad_s   [1:SW];
	side_t                side_s  [1:SW];
	logic [2:0][PW-1:0]   pairs_s [1:SW];

	for (genvar g = 0; g < SW; g++) begin : g_step
		logic               v_in;
		logic [RMW-1:0]     r_in, r_sh, trial;
		logic [SW-1:0]      q_in;
		logic [2*SW-1:0]    x_in;
		side_t              sd_in;
		logic [2:0][PW-1:0] p_in;

		if (g == 0) begin : g_first
			assign v_in  = in_vld;
			assign r_in  = '0;
			assign q_in  = '0;
			assign x_in  = in_rad;
			assign sd_in = in_side;
			assign p_in  = in_pairs;
		end else begin : g_rest
			assign v_in  = vld_s[g];
			assign r_in  = rem_s[g];
			assign q_in  = root_s[g];
			assign x_in  = rad_s[g];
			assign sd_in = side_s[g];
			assign p_in  = pairs_s[g];
		end

		assign r_sh  = {r_in[RMW-3:0], x_in[2*SW-1 -: 2]};
		assign trial = {1'b0, q_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (r_sh >= trial) begin
					rem_s[g+1]  <= r_sh - trial;
					root_s[g+1] <= {q_in[SW-2:0], 1'b1};
				end else begin
					rem_s[g+1]  <= r_sh;
					root_s[g+1] <= {q_in[SW-2:0], 1'b0};
				end
				rad_s[g+1]   <= x_in << 2;
				side_s[g+1]  <= sd_in;
				pairs_s[g+1] <= p_in;
			end
		end
	end

	assign out_vld   = vld_s[SW];
	assign out_root  = root_s[SW];
	assign out_side  = side_s[SW];
	assign out_pairs = pairs_s[SW];

endmodule

// ===== rtl/rmq_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Forms round(|p| * 2^F / (2*st)) per lane; depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_div import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SW        = 16,
	parameter int PW        = 17,
	parameter int NW        = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [SW-1:0]        in_root,
	input  side_t                in_side,
	input  logic [2:0][PW-1:0]   in_pairs,
	output logic                 out_vld,
	output logic [2:0][NW-1:0]   out_quo,
	output logic [2:0]           out_neg,
	output logic [SW-1:0]        out_half,
	output side_t                out_side
);

	localparam int DRW = SW + 2;

	logic                 vld_s  [0:NW];
	logic [2:0][DRW-1:0]  rem_s  [0:NW];
	logic [2:0][NW-1:0]   quo_s  [0:NW];
	logic [2:0][NW-1:0]   num_s  [0:NW];
	logic [2:0]           neg_s  [0:NW];
	logic [SW:0]          dvs_s  [0:NW];
	logic [SW-1:0]        half_s [0:NW];
	side_t                side_s [0:NW];

	logic [2:0][NW-1:0]   num0;
	logic [2:0]           neg0;
	logic [PW-1:0]        mag;
	logic [SW:0]          root_inc;

	always_comb begin
		num0 = '0;
		neg0 = '0;
		mag  = '0;
		for (int l = 0; l < 3; l++) begin
			neg0[l] = in_pairs[l][PW-1];
			mag     = neg0[l] ? (PW'(0) - in_pairs[l]) : in_pairs[l];
			num0[l] = (NW'(mag) << FRAC_BITS) + NW'(in_root);
		end
	end

	assign root_inc = {1'b0, in_root} + (SW+1)'(1);

	// Setup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			quo_s[0]  <= '0;
			num_s[0]  <= num0;
			neg_s[0]  <= neg0;
			dvs_s[0]  <= {in_root, 1'b0};
			half_s[0] <= root_inc[SW:1];
			side_s[0] <= in_side;
		end
	end

	for (genvar g = 0; g < NW; g++) begin : g_step
		logic [2:0][DRW-1:0] r_sh;
		logic [2:0][DRW-1:0] r_nx;
		logic [2:0]          q_bit;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				r_sh[l]  = {rem_s[g][l][DRW-2:0], num_s[g][l][NW-1]};
				q_bit[l] = (r_sh[l] >= {1'b0, dvs_s[g]});
				r_nx[l]  = q_bit[l] ? (r_sh[l] - {1'b0, dvs_s[g]}) : r_sh[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[g+1][l] <= r_nx[l];
					quo_s[g+1][l] <= {quo_s[g][l][NW-2:0], q_bit[l]};
					num_s[g+1][l] <= num_s[g][l] << 1;
				end
				neg_s[g+1]  <= neg_s[g];
				dvs_s[g+1]  <= dvs_s[g];
				half_s[g+1] <= half_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[NW];
	assign out_quo  = quo_s[NW];
	assign out_neg  = neg_s[NW];
	assign out_half = half_s[NW];
	assign out_side = side_s[NW];

endmodule

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// Pipeline: FRAC_BITS + DATA_WIDTH + ceil(RW/2) + 5 register stages, 51 at Q2.14: the front
// stage, one root bit per sqrt stage, a divider setup stage, one quotient bit per divider
// stage, and the output register.
// Throughput: one transfer per cycle; every stage holds as a whole while the output
// register is full and stalled, set by that single output register.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  mat_valid,
	output logic  mat_stall,
	input  mat_t  mat,
	output logic  quat_valid,
	input  logic  quat_stall,
	output quat_t quat
);

	localparam int DW = DATA_WIDTH;
	// Root argument width: holds three elements plus one, signed
	localparam int AW = ((DW > FRAC_BITS) ? DW : FRAC_BITS + 1) + 3;
	// Radicand is the positive argument shifted up by the fraction bits
	localparam int RW = AW - 1 + FRAC_BITS;
	localparam int SW = (RW + 1) / 2;
	// Pair sums and differences
	localparam int PW = DW + 1;
	// Divider numerator |p| << F plus st, and the quotient
	localparam int NW = PW + FRAC_BITS + 1;

	logic                en;

	logic                f_vld;
	logic [2*SW-1:0]     f_rad;
	side_t               f_side;
	logic [2:0][PW-1:0]  f_pairs;

	logic                r_vld;
	logic [SW-1:0]       r_root;
	side_t               r_side;
	logic [2:0][PW-1:0]  r_pairs;

	logic                d_vld;
	logic [2:0][NW-1:0]  d_quo;
	logic [2:0]          d_neg;
	logic [SW-1:0]       d_half;
	side_t               d_side;

	logic [3:0][DW-1:0]  comp;
	logic [1:0]          half_slot;
	logic [1:0]          lane;
	logic [NW-1:0]       half_ext;

	logic                quat_valid_q;
	quat_t               quat_q;

	// Advance the whole pipeline unless a finished result is held by the sink
	assign en        = !quat_valid_q || !quat_stall;
	assign mat_stall = !en;

	rmq_front #(
		.FRAC_BITS (FRAC_BITS),
		.AW        (AW),
		.SW        (SW),
		.PW        (PW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (mat_valid),
		.mat       (mat),
		.out_vld   (f_vld),
		.out_rad   (f_rad),
		.out_side  (f_side),
		.out_pairs (f_pairs)
	);

	rmq_sqrt #(
		.SW (SW),
		.PW (PW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (f_vld),
		.in_rad    (f_rad),
		.in_side   (f_side),
		.in_pairs  (f_pairs),
		.out_vld   (r_vld),
		.out_root  (r_root),
		.out_side  (r_side),
		.out_pairs (r_pairs)
	);

	rmq_div #(
		.FRAC_BITS (FRAC_BITS),
		.SW        (SW),
		.PW        (PW),
		.NW        (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (r_vld),
		.in_root  (r_root),
		.in_side  (r_side),
		.in_pairs (r_pairs),
		.out_vld  (d_vld),
		.out_quo  (d_quo),
		.out_neg  (d_neg),
		.out_half (d_half),
		.out_side (d_side)
	);

	// The half root goes to the w slot in the trace branch, else to the selected axis;
	// the three quotient lanes fill the remaining slots in order.
	assign half_slot = (d_side.br == BR_TRACE) ? 2'd0 : d_side.br;
	assign half_ext  = NW'(d_half);

	always_comb begin
		comp = '0;
		lane = '0;
		for (int k = 0; k < 4; k++) begin
			lane = (2'(k) < half_slot) ? 2'(k) : 2'(k - 1);
			if (d_side.bad) begin
				comp[k] = '0;
			end else if (2'(k) == half_slot) begin
				comp[k] = (half_ext > NW'((1 << (DW - 1)) - 1)) ?
					{1'b0, {(DW-1){1'b1}}} : half_ext[DW-1:0];
			end else if (!d_neg[lane]) begin
				// Clip positive magnitudes at the top of the range
				comp[k] = (d_quo[lane] > NW'((1 << (DW - 1)) - 1)) ?
					{1'b0, {(DW-1){1'b1}}} : d_quo[lane][DW-1:0];
			end else begin
				// Negate, clipping at the most negative code
				comp[k] = (d_quo[lane] > (NW'(1) << (DW - 1))) ?
					{1'b1, {(DW-1){1'b0}}} : (DW'(0) - d_quo[lane][DW-1:0]);
			end
		end
	end

	// Output register: parts the sink's stall from the pipeline data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_valid_q <= 1'b0;
		end else if (en) begin
			quat_valid_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_q.quat_w       <= comp[0];
			quat_q.quat_x       <= comp[1];
			quat_q.quat_y       <= comp[2];
			quat_q.quat_z       <= comp[3];
			quat_q.branch_taken <= d_side.br;
			quat_q.bad_input    <= d_side.bad;
		end
	end

	assign quat_valid = quat_valid_q;
	assign quat       = quat_q;

`ifndef SYNTHESIS
	// A rejected argument drives all four components to zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && quat.bad_input |->
			quat.quat_w == '0 && quat.quat_x == '0 &&
			quat.quat_y == '0 && quat.quat_z == '0)
		else $error("bad input result carries nonzero component");

	// The half root never goes negative after clipping; checked for the trace and BR_DIAG0 branches
	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat.bad_input && quat.branch_taken == BR_TRACE |->
			!quat.quat_w[DW-1])
		else $error("trace branch produced negative w");

	a_diag0_x_pos: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat.bad_input && quat.branch_taken == BR_DIAG0 |->
			!quat.quat_x[DW-1])
		else $error("diagonal branch produced negative half root");

	// Input is held back only while a result waits on a stalled sink
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		mat_stall |-> quat_valid && quat_stall)
		else $error("input stalled without a held result");
`endif

endmodule
